FILE: rtl/pulse_energy_integrator_defines.svh
// ---------------------------------------------------------------------------
// Pulse energy integrator assertion macros
// Shared assertion wrappers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef PULSE_ENERGY_INTEGRATOR_DEFINES_SVH
`define PULSE_ENERGY_INTEGRATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PEI_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pei assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PEI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pei assertion failed");
`else
`define PEI_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define PEI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pei_pkg.sv
// ---------------------------------------------------------------------------
// Pulse energy integrator package
// Widths, register indexes, codes and the scaler status bundle.
// ---------------------------------------------------------------------------
package pei_pkg;

    localparam int ADC_BITS   = 12;
    localparam int SUM_BITS   = 48;

    localparam int S_FIELDS_W = 4 * ADC_BITS;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RATE_W     = 16;
    localparam int DIVP_W     = 2 * RATE_W;
    localparam int ENERGY_W   = 32;
    localparam int PCOUNT_W   = 8;
    localparam int CHAN_W     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TWO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_US   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_DIV = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_AFT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_SEL   = 3'd7;

    localparam logic [RATE_W-1:0] ENERGY_DIV_RESET = 16'd17332;

    // Channel select codes
    localparam logic [CHAN_W-1:0] CHAN_NONE = 2'd0;
    localparam logic [CHAN_W-1:0] CHAN_ONE  = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_TWO  = 2'd2;
    localparam logic [CHAN_W-1:0] CHAN_BOTH = 2'd3;

    // Item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic busy;
        logic res_valid;
        logic energy_valid;
    } scl_status_t;

endpackage

FILE: rtl/pei_lane.sv
// ---------------------------------------------------------------------------
// Pulse energy integrator channel lane
// Gated multiply-accumulate of voltage times offset-corrected current.
// ---------------------------------------------------------------------------
module pei_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step_en,
    input  logic                               clr,
    input  logic [pei_pkg::ADC_BITS-1:0]       volt,
    input  logic [pei_pkg::ADC_BITS-1:0]       curr,
    input  logic [pei_pkg::ADC_BITS-1:0]       offset,
    input  logic [pei_pkg::ADC_BITS-1:0]       threshold,
    output logic signed [pei_pkg::SUM_BITS-1:0] sum
);
    import pei_pkg::*;

    localparam int DIFF_W = ADC_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [SUM_BITS-1:0] sum_next;

    assign diff = $signed({1'b0, curr}) - $signed({1'b0, offset});
    assign prod = PROD_W'($signed({1'b0, volt})) * PROD_W'(diff);

    always_comb begin
        sum_next = sum_reg;
        if (clr) begin
            sum_next = '0;
        end else if (step_en && (curr > threshold)) begin
            // wrap modulo 2^SUM_BITS
            sum_next = sum_reg + {{(SUM_BITS-PROD_W){prod[PROD_W-1]}}, prod};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

FILE: rtl/pei_scaler.sv
// ---------------------------------------------------------------------------
// Pulse energy integrator merge and scale unit
// Merges lane sums, scales by the sample period and divides bit-serially.
// ---------------------------------------------------------------------------
`include "pulse_energy_integrator_defines.svh"

module pei_scaler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [pei_pkg::CHAN_W-1:0]          chan_sel,
    input  logic signed [pei_pkg::SUM_BITS-1:0] sum_one,
    input  logic signed [pei_pkg::SUM_BITS-1:0] sum_two,
    input  logic [pei_pkg::RATE_W-1:0]          rate,
    input  logic [pei_pkg::RATE_W-1:0]          divisor,
    input  logic [pei_pkg::RATE_W-1:0]          ticks,
    input  logic                                res_ready,
    output pei_pkg::scl_status_t                status,
    output logic [pei_pkg::ENERGY_W-1:0]        energy
);
    import pei_pkg::*;

    localparam int MERGE_W = SUM_BITS + 1;
    localparam int PROD_W  = MERGE_W + RATE_W;
    localparam int CNT_W   = $clog2(PROD_W);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ABS  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } scl_state_t;

    scl_state_t                state_reg, state_next;
    logic signed [MERGE_W-1:0] merge_reg;
    logic [MERGE_W-1:0]        mag_reg;
    logic                      neg_reg;
    logic                      valid_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic [DIVP_W-1:0]         div_reg;
    logic [PROD_W-1:0]         dvd_reg;
    logic [DIVP_W-1:0]         rem_reg;
    logic [ENERGY_W-1:0]       quot_reg;
    logic [CNT_W-1:0]          cnt_reg;

    logic signed [MERGE_W-1:0] merge_next;
    logic [RATE_W-1:0]         div_eff;
    logic [RATE_W-1:0]         tick_eff;
    logic [DIVP_W:0]           rem_shift;
    logic                      ge;

    assign div_eff  = (divisor == '0) ? RATE_W'(1) : divisor;
    assign tick_eff = (ticks == '0) ? RATE_W'(1) : ticks;

    always_comb begin
        case (chan_sel)
            CHAN_ONE:  merge_next = MERGE_W'(sum_one);
            CHAN_TWO:  merge_next = MERGE_W'(sum_two);
            CHAN_BOTH: merge_next = MERGE_W'(sum_one) + MERGE_W'(sum_two);
            default:   merge_next = '0;
        endcase
    end

    // restoring divider step
    assign rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
    assign ge        = rem_shift >= {1'b0, div_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_ABS;
            ST_ABS:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CNT_W'(PROD_W - 1)) state_next = ST_DONE;
            ST_DONE: if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    merge_reg <= merge_next;
                    valid_reg <= (chan_sel != CHAN_NONE);
                    rate_reg  <= rate;
                    div_reg   <= DIVP_W'(div_eff) * DIVP_W'(tick_eff);
                end
            end
            ST_ABS: begin
                neg_reg <= merge_reg[MERGE_W-1];
                mag_reg <= merge_reg[MERGE_W-1] ? MERGE_W'(-merge_reg) : MERGE_W'(merge_reg);
            end
            ST_MUL: begin
                dvd_reg <= PROD_W'(mag_reg) * PROD_W'(rate_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg  <= ge ? DIVP_W'(rem_shift - {1'b0, div_reg}) : rem_shift[DIVP_W-1:0];
                dvd_reg  <= {dvd_reg[PROD_W-2:0], 1'b0};
                quot_reg <= {quot_reg[ENERGY_W-2:0], ge};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign status.busy         = (state_reg != ST_IDLE);
    assign status.res_valid    = (state_reg == ST_DONE);
    assign status.energy_valid = valid_reg;

    always_comb begin
        if (!valid_reg) begin
            energy = '0;
        end else if (neg_reg) begin
            energy = -quot_reg;
        end else begin
            energy = quot_reg;
        end
    end

    `PEI_ASSERT_IMPLY(a_start_when_idle, aclk, aresetn, start, state_reg == ST_IDLE)
    `PEI_ASSERT_IMPLY(a_rem_below_div, aclk, aresetn, state_reg == ST_DONE, rem_reg < div_reg)
    `PEI_ASSERT_IMPLY(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, div_reg != '0)

endmodule

FILE: rtl/pulse_energy_integrator.sv
// ---------------------------------------------------------------------------
// Pulse energy integrator
// Two-channel flash pulse energy accumulation with burst reporting.
// ---------------------------------------------------------------------------
// Each input beat carries one voltage and one current sample for both flash
// channels. Two lanes work side by side: each adds volt * (curr - offset) to
// its own 48-bit signed sum when the raw current is above the threshold. A
// beat with tlast closes a pulse; once report_after + 1 pulses have closed,
// the merge unit picks channel one, channel two or their sum, multiplies it
// by sample_rate_ticks and divides by energy_divisor * ticks_per_us,
// truncating toward zero, and one result beat leaves with the low 32 bits.
// All sums and the pulse count clear at that point, or on a clear beat.
// A sample or clear beat is taken and the next beat can follow at once. A
// reporting beat holds the input through the merge, the magnitude, the
// scaling multiply and 65 steps of the restoring divider, one quotient bit
// per cycle over the 65-bit scaled sum, and then the hand-over of the result
// to the output register, which waits while that register is still full.
// The output register lets the input run on while a result waits to be
// taken.
`include "pulse_energy_integrator_defines.svh"

module pulse_energy_integrator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // volt_one, curr_one, volt_two, curr_two (12 bits each, from bit 0 up)
    input  logic [pei_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                s_tlast,   // last_sample
    input  logic                                s_tuser,   // func
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [pei_pkg::ENERGY_W-1:0] m_tdata,   // energy
    output logic [1:0]                          m_tuser,   // burst_done, energy_valid
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [pei_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pei_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import pei_pkg::*;

    // configuration
    logic [ADC_BITS-1:0] threshold_reg;
    logic [ADC_BITS-1:0] offset_one_reg;
    logic [ADC_BITS-1:0] offset_two_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [RATE_W-1:0]   ticks_reg;
    logic [RATE_W-1:0]   div_reg;
    logic [PCOUNT_W-1:0] report_after_reg;
    logic [CHAN_W-1:0]   chan_sel_reg;

    // control
    logic [PCOUNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic                report_reg;
    logic                s_beat;
    logic                clear_beat;
    logic                sample_beat;
    logic                report_hit;
    logic                lane_clr;

    logic signed [SUM_BITS-1:0] sum_one;
    logic signed [SUM_BITS-1:0] sum_two;

    scl_status_t         scl_status;
    logic [ENERGY_W-1:0] scl_energy;
    logic                res_ready;

    // output register
    logic                m_valid_reg;
    logic [ENERGY_W-1:0] m_data_reg;
    logic [1:0]          m_user_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= '0;
            offset_one_reg   <= '0;
            offset_two_reg   <= '0;
            rate_reg         <= RATE_W'(1);
            ticks_reg        <= RATE_W'(1);
            div_reg          <= ENERGY_DIV_RESET;
            report_after_reg <= '0;
            chan_sel_reg     <= CHAN_NONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_THRESHOLD:  threshold_reg    <= cfg_wdata[ADC_BITS-1:0];
                REG_OFFSET_ONE: offset_one_reg   <= cfg_wdata[ADC_BITS-1:0];
                REG_OFFSET_TWO: offset_two_reg   <= cfg_wdata[ADC_BITS-1:0];
                REG_RATE_TICKS: rate_reg         <= cfg_wdata[RATE_W-1:0];
                REG_TICKS_US:   ticks_reg        <= cfg_wdata[RATE_W-1:0];
                REG_ENERGY_DIV: div_reg          <= cfg_wdata[RATE_W-1:0];
                REG_REPORT_AFT: report_after_reg <= cfg_wdata[PCOUNT_W-1:0];
                REG_CHAN_SEL:   chan_sel_reg     <= cfg_wdata[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the input while a report is being merged and scaled.
    assign s_tready    = !report_reg && !scl_status.busy;
    assign s_beat      = s_tvalid && s_tready;
    assign clear_beat  = s_beat && (s_tuser == FUNC_CLEAR);
    assign sample_beat = s_beat && (s_tuser == FUNC_SAMPLE);
    assign report_hit  = sample_beat && s_tlast && (pulse_count_reg == report_after_reg);

    // The lanes hold the updated sums while report_reg is set so the scaler
    // can take them; drop them at the same edge.
    assign lane_clr = clear_beat || report_reg;

    always_comb begin
        pulse_count_next = pulse_count_reg;
        if (lane_clr) begin
            pulse_count_next = '0;
        end else if (sample_beat && s_tlast && !report_hit) begin
            pulse_count_next = pulse_count_reg + PCOUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count_reg <= '0;
            report_reg      <= 1'b0;
        end else begin
            pulse_count_reg <= pulse_count_next;
            report_reg      <= report_hit;
        end
    end

    pei_lane u_lane_one (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (sample_beat),
        .clr       (lane_clr),
        .volt      (s_tdata[ADC_BITS-1:0]),
        .curr      (s_tdata[2*ADC_BITS-1:ADC_BITS]),
        .offset    (offset_one_reg),
        .threshold (threshold_reg),
        .sum       (sum_one)
    );

    pei_lane u_lane_two (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (sample_beat),
        .clr       (lane_clr),
        .volt      (s_tdata[3*ADC_BITS-1:2*ADC_BITS]),
        .curr      (s_tdata[4*ADC_BITS-1:3*ADC_BITS]),
        .offset    (offset_two_reg),
        .threshold (threshold_reg),
        .sum       (sum_two)
    );

    assign res_ready = !m_valid_reg || m_tready;

    pei_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (report_reg),
        .chan_sel  (chan_sel_reg),
        .sum_one   (sum_one),
        .sum_two   (sum_two),
        .rate      (rate_reg),
        .divisor   (div_reg),
        .ticks     (ticks_reg),
        .res_ready (res_ready),
        .status    (scl_status),
        .energy    (scl_energy)
    );

    // Output register: load a finished result when the slot is free or
    // being emptied in this cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (scl_status.res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (scl_status.res_valid && res_ready) begin
            m_data_reg <= scl_energy;
            m_user_reg <= {scl_status.energy_valid, 1'b1};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = $signed(m_data_reg);
    assign m_tuser  = m_user_reg;

    `PEI_ASSERT_NEXT(a_clear_zeroes_count, aclk, aresetn, clear_beat, pulse_count_reg == '0)
    `PEI_ASSERT_NEXT(a_report_clears_sums, aclk, aresetn, report_reg, (sum_one == '0) && (sum_two == '0))
    `PEI_ASSERT_IMPLY(a_no_beat_while_busy, aclk, aresetn, scl_status.busy, !s_tready)

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pulse energy integrator regression bench
// Streams flash-lamp sample beats into the integrator under several register
// settings and compares every burst report against a cycle-free prediction
// of the two-channel energy sums, their scaling and truncation.
// ---------------------------------------------------------------------------
module tb_top;

    import pei_pkg::*;

    // Slowest quiet stretch: a report, a long sender gap, a long receiver
    // stall and the settle pause. Allow many times that.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // Cycles to let pass after the last report before touching registers.
    localparam int unsigned BLOCK_LATENCY  = 80;

    typedef struct {
        logic                func;
        logic [ADC_BITS-1:0] volt_one;
        logic [ADC_BITS-1:0] curr_one;
        logic [ADC_BITS-1:0] volt_two;
        logic [ADC_BITS-1:0] curr_two;
        logic                last;
        bit                  drain_first;   // hold this beat until all reports are in
    } flash_beat_t;

    typedef struct {
        logic                       burst_done;
        logic                       energy_valid;
        logic signed [ENERGY_W-1:0] energy;
    } energy_report_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_DATA_W-1:0]        s_tdata   = '0;   // volt_one, curr_one, volt_two, curr_two
    logic                       s_tlast   = 1'b0; // last_sample
    logic                       s_tuser   = 1'b0; // func
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic signed [ENERGY_W-1:0] m_tdata;          // energy
    logic [1:0]                 m_tuser;          // burst_done, energy_valid
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

    pulse_energy_integrator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Register shadow, as written through the configuration port
    // -----------------------------------------------------------------------
    logic [ADC_BITS-1:0] cfg_threshold    = '0;
    logic [ADC_BITS-1:0] cfg_offset_one   = '0;
    logic [ADC_BITS-1:0] cfg_offset_two   = '0;
    logic [RATE_W-1:0]   cfg_rate         = 16'd1;
    logic [RATE_W-1:0]   cfg_ticks_us     = 16'd1;
    logic [RATE_W-1:0]   cfg_energy_div   = ENERGY_DIV_RESET;
    logic [PCOUNT_W-1:0] cfg_report_after = '0;
    logic [CHAN_W-1:0]   cfg_chan         = CHAN_NONE;

    // Integrator state as predicted
    logic signed [SUM_BITS-1:0] sum_one     = '0;
    logic signed [SUM_BITS-1:0] sum_two     = '0;
    logic [PCOUNT_W-1:0]        pulses_seen = '0;

    flash_beat_t    beats_to_send[$];
    energy_report_t energy_reports_due[$];
    int unsigned    beats_outstanding = 0;   // queued but not yet accepted
    int unsigned    fails = 0;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------
    // One lane: add volt * (curr - offset) when the raw current clears the
    // threshold; the sum wraps at its own width.
    function automatic logic signed [SUM_BITS-1:0] mac_lane(
        input logic signed [SUM_BITS-1:0] sum,
        input logic [ADC_BITS-1:0]        volt,
        input logic [ADC_BITS-1:0]        curr,
        input logic [ADC_BITS-1:0]        offset
    );
        logic signed [SUM_BITS-1:0] term;
        if (curr <= cfg_threshold)
            return sum;
        term = SUM_BITS'($signed({1'b0, volt})) *
               SUM_BITS'($signed({1'b0, curr}) - $signed({1'b0, offset}));
        return sum + term;
    endfunction

    // Multiply by the sample rate, divide by divisor * ticks (zero reads as
    // one), truncate toward zero and keep the low 32 bits.
    function automatic logic [ENERGY_W-1:0] scale_burst(input logic signed [127:0] total);
        logic [127:0]      magnitude;
        logic [127:0]      divisor;
        logic [127:0]      quotient;
        logic [RATE_W-1:0] div_eff;
        logic [RATE_W-1:0] tpu_eff;
        div_eff   = (cfg_energy_div == '0) ? 16'd1 : cfg_energy_div;
        tpu_eff   = (cfg_ticks_us == '0) ? 16'd1 : cfg_ticks_us;
        magnitude = total[127] ? -total : total;
        magnitude = magnitude * 128'(cfg_rate);
        divisor   = 128'(div_eff) * 128'(tpu_eff);
        quotient  = magnitude / divisor;
        return total[127] ? -quotient[ENERGY_W-1:0] : quotient[ENERGY_W-1:0];
    endfunction

    // Advance the predicted state by one accepted beat; queue a report when
    // the beat closes the last pulse of a burst.
    function automatic void integrate_beat(input flash_beat_t b);
        energy_report_t         rep;
        logic signed [127:0]    total;
        if (b.func == FUNC_CLEAR) begin
            sum_one     = '0;
            sum_two     = '0;
            pulses_seen = '0;
            return;
        end
        sum_one = mac_lane(sum_one, b.volt_one, b.curr_one, cfg_offset_one);
        sum_two = mac_lane(sum_two, b.volt_two, b.curr_two, cfg_offset_two);
        if (!b.last)
            return;
        if (pulses_seen != cfg_report_after) begin
            pulses_seen = pulses_seen + 1'b1;
            return;
        end
        rep.burst_done   = 1'b1;
        rep.energy_valid = 1'b1;
        total            = '0;
        case (cfg_chan)
            CHAN_ONE: total = 128'(sum_one);
            CHAN_TWO: total = 128'(sum_two);
            CHAN_BOTH: begin
                total = 128'(sum_one);
                total = total + 128'(sum_two);
            end
            default: rep.energy_valid = 1'b0;
        endcase
        rep.energy = rep.energy_valid ? scale_burst(total) : '0;
        energy_reports_due.push_back(rep);
        sum_one     = '0;
        sum_two     = '0;
        pulses_seen = '0;
    endfunction

    // -----------------------------------------------------------------------
    // Idle shaping: mostly back-to-back, some short gaps, a few long ones.
    // A quiet flag gives stretches with no idling at all.
    // -----------------------------------------------------------------------
    logic send_quiet = 1'b0;
    logic recv_quiet = 1'b0;

    function automatic int unsigned pick_gap(input logic quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // -----------------------------------------------------------------------
    // Driver: hold a beat until taken, predict on acceptance, then either
    // idle or present the next pending beat.
    // -----------------------------------------------------------------------
    flash_beat_t beat_on_bus;
    int unsigned send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                integrate_beat(beat_on_bus);
                beats_outstanding--;
            end
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (beats_to_send.size() != 0 &&
                         !(beats_to_send[0].drain_first && energy_reports_due.size() != 0)) begin
                beat_on_bus = beats_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {beat_on_bus.curr_two, beat_on_bus.volt_two,
                             beat_on_bus.curr_one, beat_on_bus.volt_one};
                s_tlast  <= beat_on_bus.last;
                s_tuser  <= beat_on_bus.func;
                send_gap = pick_gap(send_quiet);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest pending report, then
    // decide on back-pressure for the next cycle.
    // -----------------------------------------------------------------------
    int unsigned    recv_stall = 0;
    energy_report_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (energy_reports_due.size() == 0) begin
                    $error("unexpected result beat: energy %0d tuser %b", m_tdata, m_tuser);
                    fails++;
                end else begin
                    want = energy_reports_due.pop_front();
                    if (m_tuser[0] !== want.burst_done) begin
                        $error("burst_done: expected %0b, got %0b", want.burst_done, m_tuser[0]);
                        fails++;
                    end
                    if (m_tuser[1] !== want.energy_valid) begin
                        $error("energy_valid: expected %0b, got %0b",
                               want.energy_valid, m_tuser[1]);
                        fails++;
                    end
                    if (m_tdata !== want.energy) begin
                        $error("energy: expected %0d, got %0d", want.energy, m_tdata);
                        fails++;
                    end
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                recv_stall = pick_gap(recv_quiet);
                m_tready <= (recv_stall == 0);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog, plus re-rolling of the quiet stretches
    // -----------------------------------------------------------------------
    int unsigned idle_cycles = 0;
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0) begin
            send_quiet <= ($urandom_range(0, 3) == 0);
            recv_quiet <= ($urandom_range(0, 3) == 0);
        end
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("pulse_energy_integrator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    task automatic send_beat(
        input logic                func,
        input logic [ADC_BITS-1:0] volt_one,
        input logic [ADC_BITS-1:0] curr_one,
        input logic [ADC_BITS-1:0] volt_two,
        input logic [ADC_BITS-1:0] curr_two,
        input logic                last,
        input bit                  drain_first
    );
        flash_beat_t b;
        b.func        = func;
        b.volt_one    = volt_one;
        b.curr_one    = curr_one;
        b.volt_two    = volt_two;
        b.curr_two    = curr_two;
        b.last        = last;
        b.drain_first = drain_first;
        beats_outstanding++;
        beats_to_send.push_back(b);
    endtask

    // Wait until every queued beat is taken and every report has come back,
    // then let the pipeline run dry.
    task automatic settle();
        while (beats_outstanding != 0 || energy_reports_due.size() != 0)
            @(posedge aclk);
        repeat (BLOCK_LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_THRESHOLD:  cfg_threshold    = value[ADC_BITS-1:0];
            REG_OFFSET_ONE: cfg_offset_one   = value[ADC_BITS-1:0];
            REG_OFFSET_TWO: cfg_offset_two   = value[ADC_BITS-1:0];
            REG_RATE_TICKS: cfg_rate         = value;
            REG_TICKS_US:   cfg_ticks_us     = value;
            REG_ENERGY_DIV: cfg_energy_div   = value;
            REG_REPORT_AFT: cfg_report_after = value[PCOUNT_W-1:0];
            REG_CHAN_SEL:   cfg_chan         = value[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(
        input int unsigned threshold, input int unsigned off_one, input int unsigned off_two,
        input int unsigned rate, input int unsigned tpu, input int unsigned divisor,
        input int unsigned report_after, input logic [CHAN_W-1:0] chan
    );
        write_reg(REG_THRESHOLD,  CFG_DATA_W'(threshold));
        write_reg(REG_OFFSET_ONE, CFG_DATA_W'(off_one));
        write_reg(REG_OFFSET_TWO, CFG_DATA_W'(off_two));
        write_reg(REG_RATE_TICKS, CFG_DATA_W'(rate));
        write_reg(REG_TICKS_US,   CFG_DATA_W'(tpu));
        write_reg(REG_ENERGY_DIV, CFG_DATA_W'(divisor));
        write_reg(REG_REPORT_AFT, CFG_DATA_W'(report_after));
        write_reg(REG_CHAN_SEL,   CFG_DATA_W'(chan));
    endtask

    // Extremes of a range a fair share of the time, otherwise anything in it.
    function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return lo;
        if (r < 4)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    // Any ADC code.
    function automatic logic [ADC_BITS-1:0] pick_sample();
        return ADC_BITS'($urandom_range(0, 4095));
    endfunction

    // Bias currents above the threshold so most samples integrate.
    function automatic logic [ADC_BITS-1:0] pick_current();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return ADC_BITS'($urandom_range(0, 4095));
        if (r < 8)
            return ADC_BITS'($urandom_range(cfg_threshold, 4095));
        return (r == 8) ? 12'd0 : 12'd4095;
    endfunction

    task automatic roll_settings(input int unsigned report_after);
        apply_settings(pick_value(0, 4095) / (($urandom_range(0, 2) == 0) ? 1 : 8),
                       pick_value(0, 4095), pick_value(0, 4095),
                       pick_value(1, 65535), pick_value(0, 65535), pick_value(0, 65535),
                       report_after, CHAN_W'($urandom_range(0, 3)));
    endtask

    // A well-formed pulse: samples with random content, tlast on the final one.
    task automatic send_pulse(input int unsigned len, input bit drain_first);
        for (int i = 0; i < len; i++)
            send_beat(FUNC_SAMPLE, pick_sample(), pick_current(),
                      pick_sample(), pick_current(), i == len - 1,
                      drain_first && i == 0);
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        int unsigned r;
        int unsigned len;
        int unsigned sent;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, no channel selected: a clear beat with tlast is
        // ignored, then a burst reports with energy_valid low and zero energy.
        send_beat(FUNC_CLEAR, '1, '1, '1, '1, 1'b1, 0);
        send_beat(FUNC_SAMPLE, '1, '1, '1, '1, 1'b0, 0);
        send_beat(FUNC_SAMPLE, '0, '0, '0, '0, 1'b1, 0);
        settle();

        // Both channels, two pulses per burst, threshold edge and a negative
        // difference on channel one; the big rate overflows 32 bits.
        apply_settings(2000, 4095, 0, 65535, 1, 1, 1, CHAN_BOTH);
        send_beat(FUNC_SAMPLE, 12'd4095, 12'd2000, 12'd4095, 12'd2001, 1'b0, 0);
        send_beat(FUNC_SAMPLE, 12'd4095, 12'd2001, 12'd0, 12'd4095, 1'b1, 0);
        send_beat(FUNC_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 0);
        settle();

        // Channel one, zero divisors act as one, clear in the middle of a pulse.
        apply_settings(0, 0, 4095, 1, 0, 0, 0, CHAN_ONE);
        send_beat(FUNC_SAMPLE, '1, '1, '1, '1, 1'b0, 0);
        send_beat(FUNC_CLEAR, '0, '0, '0, '0, 1'b0, 0);
        send_beat(FUNC_SAMPLE, 12'd1, 12'd1, 12'd4095, 12'd1, 1'b1, 0);
        settle();

        // Channel two with the highest threshold: nothing integrates.
        apply_settings(4095, 0, 4095, 65535, 65535, 65535, 0, CHAN_TWO);
        send_beat(FUNC_SAMPLE, '1, '1, '1, '1, 1'b1, 0);
        settle();

        // Channel two with a negative sum and unit scaling.
        apply_settings(0, 0, 4095, 1, 1, 1, 0, CHAN_TWO);
        send_beat(FUNC_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 12'd1, 1'b1, 0);
        settle();

        // Longest burst: 256 pulses before one report, mostly one-beat pulses.
        roll_settings(255);
        write_reg(REG_CHAN_SEL, CFG_DATA_W'(CHAN_BOTH));
        for (int i = 0; i < 300; i++)
            send_beat(FUNC_SAMPLE, pick_sample(), pick_current(),
                      pick_sample(), pick_current(),
                      $urandom_range(0, 9) != 0, 0);
        send_beat(FUNC_CLEAR, pick_sample(), pick_sample(),
                  pick_sample(), pick_sample(), $urandom_range(0, 1) != 0, 0);
        settle();

        // Random phases: mostly well-formed pulses, some clears and stray
        // samples; a few pulses wait for every report to drain first.
        for (int p = 0; p < 8; p++) begin
            roll_settings(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
            send_beat(FUNC_CLEAR, pick_sample(), pick_sample(),
                      pick_sample(), pick_sample(),
                      $urandom_range(0, 1) != 0, 0);
            sent = 0;
            while (sent < 75) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    send_beat(FUNC_CLEAR, pick_sample(), pick_sample(),
                              pick_sample(), pick_sample(),
                              $urandom_range(0, 1) != 0, 0);
                    sent++;
                end else if (r < 10) begin
                    send_beat(FUNC_SAMPLE, pick_sample(), pick_sample(),
                              pick_sample(), pick_sample(),
                              $urandom_range(0, 1) != 0, 0);
                    sent++;
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                      : $urandom_range(1, 6);
                    send_pulse(len, $urandom_range(0, 9) == 0);
                    sent += len;
                end
            end
            settle();
        end

        settle();
        if (energy_reports_due.size() != 0) begin
            $error("%0d reports never arrived", energy_reports_due.size());
            fails++;
        end
        if (fails == 0)
            $display("pulse_energy_integrator regression: pass");
        else
            $display("pulse_energy_integrator regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pei_pkg.sv
rtl/pei_lane.sv
rtl/pei_scaler.sv
rtl/pulse_energy_integrator.sv
verif/tb_top.sv
